FILE: rtl/flash_page_ring_queue_defines.svh
// Assertion macros shared by the flash page ring queue RTL.
`ifndef FLASH_PAGE_RING_QUEUE_DEFINES_SVH
`define FLASH_PAGE_RING_QUEUE_DEFINES_SVH

// Clocked check that is ignored while reset is asserted.
`define FPRQ_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define FPRQ_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fprq_pkg.sv
// Types and constants of the flash page ring queue controller.
`default_nettype none

package fprq_pkg;

    // Geometry of the flash and of the queue items.
    localparam int PAGE_BYTES     = 1024;
    localparam int MAX_PAGES      = 32;
    localparam int MAX_ITEM_BYTES = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_PAGE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_BYTES = 2'd2;

    // Operation codes of an input beat; the fourth code does nothing.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Item counter saturates at its all-ones value.
    localparam logic [13:0] TOTAL_MAX = 14'h3FFF;

    // Flash commands issued on the result channel.
    typedef enum logic [1:0] {
        CMD_ERASE   = 2'd0,
        CMD_PROGRAM = 2'd1,
        CMD_READ    = 2'd2,
        CMD_EMPTY   = 2'd3
    } command_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] data_low;
        logic [63:0] data_high;
    } item_t;

    typedef struct packed {
        command_t    command;
        logic [4:0]  flash_page;
        logic [9:0]  byte_offset;
        logic [63:0] item_low;
        logic [63:0] item_high;
        logic [13:0] items_held;
        logic        last;
    } result_t;

    // Builds a result beat with count and last flag still clear.
    function automatic result_t make_result(
        input command_t    cmd,
        input logic [4:0]  page,
        input logic [9:0]  offset,
        input logic [63:0] lo,
        input logic [63:0] hi
    );
        result_t r;
        r.command     = cmd;
        r.flash_page  = page;
        r.byte_offset = offset;
        r.item_low    = lo;
        r.item_high   = hi;
        r.items_held  = 14'd0;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/flash_page_ring_queue.sv
// An accepted input beat is held in the input register, and its result beats are then
// registered in the two-entry result buffer once that buffer has room for them.
// Throughput: one input beat per cycle while the result port does not stall and each beat
// makes one result beat; a push that erases the oldest page, or a pop that leaves its page,
// makes two result beats and holds back the next input, as the result port moves one beat a cycle.
// Reset clears all pointers and the item count, and sets base page 0, one ring page, 4-byte slots.
`default_nettype none

module flash_page_ring_queue (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire fprq_pkg::item_t                    item,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output fprq_pkg::result_t                       result,
    input  wire logic                               cfg_write,
    input  wire logic [fprq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fprq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    `include "flash_page_ring_queue_defines.svh"

    // Slots per page for each legal slot size, capped at 256.
    localparam int SPP_4  = (fprq_pkg::PAGE_BYTES / 4  > 256) ? 256 : fprq_pkg::PAGE_BYTES / 4;
    localparam int SPP_8  = (fprq_pkg::PAGE_BYTES / 8  > 256) ? 256 : fprq_pkg::PAGE_BYTES / 8;
    localparam int SPP_12 = (fprq_pkg::PAGE_BYTES / 12 > 256) ? 256 : fprq_pkg::PAGE_BYTES / 12;
    localparam int SPP_16 = (fprq_pkg::PAGE_BYTES / 16 > 256) ? 256 : fprq_pkg::PAGE_BYTES / 16;

    // Configuration registers.
    logic [4:0] base_page_reg;
    logic [5:0] page_count_reg;
    logic [4:0] slot_bytes_reg;

    // Queue pointers and item count.
    logic [4:0]  rd_page_reg, rd_page_next;
    logic [7:0]  rd_slot_reg, rd_slot_next;
    logic [4:0]  wr_page_reg, wr_page_next;
    logic [7:0]  wr_slot_reg, wr_slot_next;
    logic [13:0] total_reg, total_next;

    // Input register and two-entry result buffer.
    fprq_pkg::item_t   in_reg;
    logic              in_full_reg;
    fprq_pkg::result_t res0_reg, res1_reg;
    logic [1:0]        cnt_reg;

    // Derived geometry.
    logic [4:0]  slot_clamp;
    logic [4:0]  slot_size;
    logic [8:0]  spp;
    logic [5:0]  pages;
    logic [4:0]  last_page;

    // Step datapath.
    logic              accept;
    logic              deliver;
    logic              process;
    logic              hit;
    logic [8:0]        drop;
    logic [13:0]       total_dropped;
    logic [13:0]       total_base;
    logic [13:0]       total_push;
    logic [8:0]        wr_slot_inc;
    logic [8:0]        rd_slot_inc;
    logic [7:0]        off_slot;
    logic [12:0]       off_prod;
    logic [9:0]        offset;
    logic [63:0]       keep_low;
    logic [63:0]       keep_high;
    logic [4:0]        rd_abs;
    logic [4:0]        wr_abs;
    fprq_pkg::result_t res_a, res_b;
    logic [1:0]        n_res;

    // Ring index that follows idx.
    function automatic logic [4:0] ring_next(input logic [4:0] idx, input logic [4:0] lastp);
        return (idx >= lastp) ? 5'd0 : idx + 5'd1;
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg  <= 5'd0;
            page_count_reg <= 6'd1;
            slot_bytes_reg <= 5'd4;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fprq_pkg::CFG_BASE_PAGE:  base_page_reg  <= cfg_data[4:0];
                fprq_pkg::CFG_PAGE_COUNT: page_count_reg <= cfg_data;
                fprq_pkg::CFG_SLOT_BYTES: slot_bytes_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effective slot size, a multiple of four from 4 to the item maximum.
    always_comb
    begin
        if (slot_bytes_reg < 5'd4)
            slot_clamp = 5'd4;
        else if (slot_bytes_reg > 5'(fprq_pkg::MAX_ITEM_BYTES))
            slot_clamp = 5'(fprq_pkg::MAX_ITEM_BYTES);
        else
            slot_clamp = slot_bytes_reg;
        slot_size = (slot_clamp + 5'd3) & 5'b11100;
    end

    // Slots per page, looked up by slot size in words.
    always_comb
    begin
        case (slot_size[4:2])
            3'd1:    spp = 9'(SPP_4);
            3'd2:    spp = 9'(SPP_8);
            3'd3:    spp = 9'(SPP_12);
            3'd4:    spp = 9'(SPP_16);
            default: spp = 9'd1;
        endcase
    end

    // Effective ring length and its last index.
    assign pages = (page_count_reg == 6'd0) ? 6'd1 :
                   (page_count_reg > 6'(fprq_pkg::MAX_PAGES)) ? 6'(fprq_pkg::MAX_PAGES) :
                   page_count_reg;
    assign last_page = 5'(pages - 6'd1);

    // Handshakes.
    assign deliver      = (cnt_reg != 2'd0) && !result_stall;
    assign process      = in_full_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && deliver));
    assign item_stall   = in_full_reg && !process;
    assign accept       = item_valid && !item_stall;
    assign result_valid = (cnt_reg != 2'd0);
    assign result       = res0_reg;

    // Overwrite detection and the count after dropping the oldest page.
    assign hit           = (wr_page_reg == rd_page_reg) && (wr_slot_reg <= rd_slot_reg) &&
                           (total_reg != 14'd0);
    assign drop          = ({1'b0, rd_slot_reg} < spp) ? spp - {1'b0, rd_slot_reg} : 9'd0;
    assign total_dropped = ({5'd0, drop} >= total_reg) ? 14'd0 : total_reg - {5'd0, drop};
    assign total_base    = hit ? total_dropped : total_reg;
    assign total_push    = (total_base != fprq_pkg::TOTAL_MAX) ? total_base + 14'd1 : total_base;

    // Slot advance and byte offset of the addressed slot.
    assign wr_slot_inc = {1'b0, wr_slot_reg} + 9'd1;
    assign rd_slot_inc = {1'b0, rd_slot_reg} + 9'd1;
    assign off_slot    = (in_reg.operation == fprq_pkg::OP_PUSH) ? wr_slot_reg : rd_slot_reg;
    assign off_prod    = {5'd0, off_slot} * {8'd0, slot_size};
    assign offset      = off_prod[9:0];

    // Absolute flash pages.
    assign rd_abs = base_page_reg + rd_page_reg;
    assign wr_abs = base_page_reg + wr_page_reg;

    // Bytes past the slot are sent as zero.
    assign keep_low  = (slot_size >= 5'd8) ? in_reg.data_low : {32'd0, in_reg.data_low[31:0]};
    assign keep_high = (slot_size >= 5'd16) ? in_reg.data_high :
                       (slot_size >= 5'd12) ? {32'd0, in_reg.data_high[31:0]} : 64'd0;

    // One step of the queue: results and next pointers.
    always_comb
    begin
        rd_page_next = rd_page_reg;
        rd_slot_next = rd_slot_reg;
        wr_page_next = wr_page_reg;
        wr_slot_next = wr_slot_reg;
        total_next   = total_reg;
        res_a = fprq_pkg::make_result(fprq_pkg::CMD_EMPTY, 5'd0, 10'd0, 64'd0, 64'd0);
        res_b = fprq_pkg::make_result(fprq_pkg::CMD_EMPTY, 5'd0, 10'd0, 64'd0, 64'd0);
        n_res = 2'd0;
        case (in_reg.operation)
            fprq_pkg::OP_PUSH:
            begin
                if (hit)
                begin
                    res_a = fprq_pkg::make_result(fprq_pkg::CMD_ERASE, rd_abs, 10'd0,
                                                  64'd0, 64'd0);
                    res_b = fprq_pkg::make_result(fprq_pkg::CMD_PROGRAM, wr_abs, offset,
                                                  keep_low, keep_high);
                    n_res = 2'd2;
                    rd_page_next = ring_next(rd_page_reg, last_page);
                    rd_slot_next = 8'd0;
                end
                else
                begin
                    res_a = fprq_pkg::make_result(fprq_pkg::CMD_PROGRAM, wr_abs, offset,
                                                  keep_low, keep_high);
                    n_res = 2'd1;
                end
                total_next = total_push;
                if (wr_slot_inc >= spp)
                begin
                    wr_page_next = ring_next(wr_page_reg, last_page);
                    wr_slot_next = 8'd0;
                end
                else
                begin
                    wr_slot_next = wr_slot_inc[7:0];
                end
            end
            fprq_pkg::OP_POP:
            begin
                if (total_reg == 14'd0)
                begin
                    n_res = 2'd1;
                end
                else
                begin
                    res_a = fprq_pkg::make_result(fprq_pkg::CMD_READ, rd_abs, offset,
                                                  64'd0, 64'd0);
                    total_next = total_reg - 14'd1;
                    if (rd_slot_inc >= spp)
                    begin
                        // Leaving the page: erase it behind the read.
                        res_b = fprq_pkg::make_result(fprq_pkg::CMD_ERASE, rd_abs, 10'd0,
                                                      64'd0, 64'd0);
                        n_res = 2'd2;
                        rd_page_next = ring_next(rd_page_reg, last_page);
                        rd_slot_next = 8'd0;
                    end
                    else
                    begin
                        n_res = 2'd1;
                        rd_slot_next = rd_slot_inc[7:0];
                    end
                end
            end
            fprq_pkg::OP_CLEAR:
            begin
                rd_page_next = 5'd0;
                rd_slot_next = 8'd0;
                wr_page_next = 5'd0;
                wr_slot_next = 8'd0;
                total_next   = 14'd0;
                res_a = fprq_pkg::make_result(fprq_pkg::CMD_ERASE, base_page_reg, 10'd0,
                                              64'd0, 64'd0);
                n_res = 2'd1;
            end
            default: ;
        endcase
        res_a.items_held = total_next;
        res_b.items_held = total_next;
        res_a.last       = (n_res == 2'd1);
        res_b.last       = 1'b1;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (accept)
            in_full_reg <= 1'b1;
        else if (process)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= item;
    end

    // Queue state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_page_reg <= 5'd0;
            rd_slot_reg <= 8'd0;
            wr_page_reg <= 5'd0;
            wr_slot_reg <= 8'd0;
            total_reg   <= 14'd0;
        end
        else if (process)
        begin
            rd_page_reg <= rd_page_next;
            rd_slot_reg <= rd_slot_next;
            wr_page_reg <= wr_page_next;
            wr_slot_reg <= wr_slot_next;
            total_reg   <= total_next;
        end
    end

    // Result buffer count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (process)
            cnt_reg <= n_res;
        else if (deliver)
            cnt_reg <= cnt_reg - 2'd1;
    end

    // Result buffer payload; the second beat moves up as the first leaves.
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            res0_reg <= res_a;
            res1_reg <= res_b;
        end
        else if (deliver)
        begin
            res0_reg <= res1_reg;
        end
    end

    // The buffer never holds more than the two beats of one step.
    `FPRQ_CHECK(a_cnt_range, cnt_reg != 2'd3, "result buffer count out of range")

    // The beat shown is the final one exactly when it is the only one left.
    `FPRQ_CHECK(a_last_flag, (cnt_reg != 2'd0) |-> (res0_reg.last == (cnt_reg == 2'd1)),
                "last flag does not match buffered beats")

    // Buffered beats report the count left by the step that made them.
    `FPRQ_CHECK(a_held_count, (cnt_reg != 2'd0) |-> (res0_reg.items_held == total_reg),
                "items held differs from the item count")

    // A clear leaves an empty queue with both pointers at ring page zero.
    `FPRQ_CHECK(a_clear_state,
                (process && (in_reg.operation == fprq_pkg::OP_CLEAR)) |=>
                ((total_reg == 14'd0) && (rd_page_reg == 5'd0) && (wr_page_reg == 5'd0)),
                "clear did not reset the queue")

endmodule

`default_nettype wire
